// File: rtl/l5mdl_pkg.sv
// Shared types and constants for the Lagrange modulated delay line.
// No dependencies; imported by l5mdl_cfg_if, the controller, the datapath and the top level.
`default_nettype none

package l5mdl_pkg;

  localparam int REG_W     = 29;  // Q13.16 delay registers
  localparam int CFG_IDX_W = 2;
  localparam int LFO_W     = 16;
  // extra quotient bits beyond the sample width in the final /15 step
  localparam int QUO_EXTRA = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE = 2'd0,
    CFG_DEPTH  = 2'd1,
    CFG_MIN    = 2'd2,
    CFG_MAX    = 2'd3
  } cfg_idx_t;

  localparam logic [REG_W-1:0] CENTRE_RST = 29'd22020096;
  localparam logic [REG_W-1:0] DEPTH_RST  = 29'd62914560;
  localparam logic [REG_W-1:0] MIN_RST    = 29'd262144;
  localparam logic [REG_W-1:0] MAX_RST    = 29'd346030080;

  typedef struct packed {
    logic       clear;
    logic       accept;
    logic       mul_delay;
    logic       clamp;
    logic       mod_q;
    logic       mod_r;
    logic       quo_load;
    logic       quo_mul;
    logic       base;
    logic       w_init;
    logic       w_mul;
    logic       w_rnd;
    logic       x_mul;
    logic       x_acc;
    logic       out_load;
    logic [2:0] tap_i;
    logic [2:0] fac_j;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } st_t;

endpackage

`default_nettype wire

// File: rtl/l5mdl_if.sv
// Handshake interfaces for the request, result and configuration channels.
// Depends on l5mdl_pkg for the configuration field widths.
`default_nettype none

interface l5mdl_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic signed [15:0]            lfo_value;

  modport source (output valid, channel, sample_in, lfo_value, input ready);
  modport sink   (input valid, channel, sample_in, lfo_value, output ready);
endinterface

interface l5mdl_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

interface l5mdl_cfg_if import l5mdl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/l5mdl_ctrl.sv
// Sequencer for the delay line: clearing pass, delay, modulo, tap loop, final divide.
// Depends on l5mdl_pkg for the command and status structs.
`default_nettype none

module l5mdl_ctrl import l5mdl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  st_t  st,
  output cmd_t cmd
);

  localparam logic [2:0] LAST_TAP = 3'd5;
  localparam logic [2:0] LAST_FAC = 3'd4;

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_DELAY = 15'h0004,
    S_CLAMP = 15'h0008,
    S_MODL  = 15'h0010,
    S_MOD   = 15'h0020,
    S_BASE  = 15'h0040,
    S_WINIT = 15'h0080,
    S_WMUL  = 15'h0100,
    S_WRND  = 15'h0200,
    S_XMUL  = 15'h0400,
    S_XACC  = 15'h0800,
    S_QLOAD = 15'h1000,
    S_QDIV  = 15'h2000,
    S_OUT   = 15'h4000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] i_r, i_nxt;
  logic [2:0] k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.tap_i = i_r;
    // factor index skips the tap's own term
    cmd.fac_j = (k_r >= i_r) ? k_r + 3'd1 : k_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DELAY;
        end
      end
      S_DELAY: begin
        cmd.mul_delay = 1'b1;
        state_nxt     = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_MODL;
      end
      S_MODL: begin
        cmd.mod_q = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_r = 1'b1;
        state_nxt = S_BASE;
      end
      S_BASE: begin
        cmd.base  = 1'b1;
        i_nxt     = '0;
        k_nxt     = '0;
        state_nxt = S_WINIT;
      end
      S_WINIT: begin
        cmd.w_init = 1'b1;
        k_nxt      = 3'd1;
        state_nxt  = S_WMUL;
      end
      S_WMUL: begin
        cmd.w_mul = 1'b1;
        state_nxt = S_WRND;
      end
      S_WRND: begin
        cmd.w_rnd = 1'b1;
        if (k_r == LAST_FAC) begin
          state_nxt = S_XMUL;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = S_WMUL;
        end
      end
      S_XMUL: begin
        cmd.x_mul = 1'b1;
        state_nxt = S_XACC;
      end
      S_XACC: begin
        cmd.x_acc = 1'b1;
        if (i_r == LAST_TAP) begin
          state_nxt = S_QLOAD;
        end else begin
          i_nxt     = i_r + 3'd1;
          k_nxt     = '0;
          state_nxt = S_WINIT;
        end
      end
      S_QLOAD: begin
        cmd.quo_load = 1'b1;
        state_nxt    = S_QDIV;
      end
      S_QDIV: begin
        cmd.quo_mul = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      i_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/l5mdl_datapath.sv
// Datapath: config registers, delay memory, write pointers, multipliers, constant dividers.
// Depends on l5mdl_pkg; driven by l5mdl_ctrl through cmd_t.
`default_nettype none

module l5mdl_datapath import l5mdl_pkg::*; #(
  parameter int BUFFER_DEPTH  = 8192,
  parameter int CHANNEL_COUNT = 2,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output st_t                           st,
  input  logic                          cfg_wr,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [REG_W-1:0]              cfg_data,
  input  logic                          channel,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [LFO_W-1:0]       lfo_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int PW        = $clog2(BUFFER_DEPTH);
  localparam int MEM_DEPTH = CHANNEL_COUNT * BUFFER_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int CHW       = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int DIV_W     = SAMPLE_BITS + QUO_EXTRA;
  localparam int XP_W      = SAMPLE_BITS + 26;
  localparam int ACC_W     = SAMPLE_BITS + 29;
  localparam int BACK_W    = REG_W - 16 + 1;
  localparam int DPROD_W   = REG_W + LFO_W;
  localparam int QUO_DIV   = 15;
  localparam int RND_SHIFT = 19;
  // reciprocals: ceil(2^(N+l)/d) is exact for every N-bit dividend
  localparam int     MOD_SH  = BACK_W + PW;
  localparam int     MODM_W  = BACK_W + 2;
  localparam longint MOD_M   = ((64'd1 << MOD_SH) + BUFFER_DEPTH - 1) / BUFFER_DEPTH;
  localparam int     QUO_SH  = DIV_W + 4;
  localparam int     QUOM_W  = DIV_W + 1;
  localparam longint QUO_M   = ((64'd1 << QUO_SH) + QUO_DIV - 1) / QUO_DIV;
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(3932160);
  localparam logic [DIV_W-1:0] SAT_HI   =
    DIV_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [DIV_W-1:0] SAT_LO_MAG = SAT_HI + 1'b1;

  // configuration
  logic [REG_W-1:0] centre_r, depth_r, min_r, max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r <= CENTRE_RST;
      depth_r  <= DEPTH_RST;
      min_r    <= MIN_RST;
      max_r    <= MAX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTRE: centre_r <= cfg_data;
        CFG_DEPTH:  depth_r  <= cfg_data;
        CFG_MIN:    min_r    <= cfg_data;
        CFG_MAX:    max_r    <= cfg_data;
        default:    centre_r <= centre_r;
      endcase
    end
  end

  // write side
  logic [CHW-1:0] ch_in, ch_r;
  logic [PW-1:0]  wp_r [CHANNEL_COUNT];
  logic [PW-1:0]  wp_cur, wp_inc, wp_new_r;
  logic [AW-1:0]  wr_addr, rd_addr, clr_r;
  logic [LFO_W-1:0] lfo_off_r;

  assign ch_in   = (CHANNEL_COUNT > 1) ? CHW'(channel) : '0;
  assign wp_cur  = wp_r[ch_in];
  assign wp_inc  = (wp_cur == PW'(BUFFER_DEPTH - 1)) ? '0 : wp_cur + 1'b1;
  assign wr_addr = AW'(ch_in) * AW'(BUFFER_DEPTH) + AW'(wp_cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) wp_r[c] <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.accept) wp_r[ch_in] <= wp_inc;
      if (cmd.clear) clr_r <= clr_r + 1'b1;
    end
  end

  assign st.clear_last = (clr_r == AW'(MEM_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r      <= ch_in;
      wp_new_r  <= wp_inc;
      // offset binary: lfo + 1 in Q1.15
      lfo_off_r <= lfo_value ^ {1'b1, {(LFO_W-1){1'b0}}};
    end
  end

  // delay and clamp
  logic [DPROD_W-1:0]     dprod_r;
  logic signed [31:0]     d_sum;
  logic [REG_W-1:0]       d_r, d_clamped;
  logic [BACK_W-1:0]      back;

  assign d_sum = $signed({2'b00, dprod_r[DPROD_W-1:15]}) - $signed({3'b000, depth_r})
               + $signed({3'b000, centre_r});

  always_comb begin
    if (d_sum < $signed({3'b000, min_r}))      d_clamped = min_r;
    else if (d_sum > $signed({3'b000, max_r})) d_clamped = max_r;
    else                                       d_clamped = d_sum[REG_W-1:0];
  end

  assign back = BACK_W'(d_r[REG_W-1:16]) + BACK_W'(d_r[15:0] != 16'd0);

  always_ff @(posedge clk) begin
    if (cmd.mul_delay) dprod_r <= depth_r * lfo_off_r;
    if (cmd.clamp)     d_r     <= d_clamped;
  end

  // back mod BUFFER_DEPTH and the final divide by 15, by reciprocal multiplication
  logic signed [ACC_W-1:0]  acc_r;
  logic [BACK_W-1:0]        mq_r, mrem;
  logic [PW-1:0]            rem_r;
  logic [DIV_W-1:0]         dvd_r, quo_r;
  logic                     neg_r;
  logic [ACC_W-1:0]         acc_mag, acc_rnd;
  logic [BACK_W+MODM_W-1:0] mprod;
  logic [DIV_W+QUOM_W-1:0]  qprod;

  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign acc_rnd = acc_mag + RND_HALF;
  assign mprod   = (BACK_W+MODM_W)'(back) * (BACK_W+MODM_W)'(MOD_M);
  // q*depth never exceeds back, so the product is exact at this width
  assign mrem    = back - BACK_W'(mq_r * BACK_W'(BUFFER_DEPTH));
  assign qprod   = (DIV_W+QUOM_W)'(dvd_r) * (DIV_W+QUOM_W)'(QUO_M);

  always_ff @(posedge clk) begin
    if (cmd.mod_q) mq_r  <= BACK_W'(mprod >> MOD_SH);
    if (cmd.mod_r) rem_r <= PW'(mrem);
    if (cmd.quo_load) begin
      dvd_r <= acc_rnd[ACC_W-1:RND_SHIFT];
      neg_r <= acc_r[ACC_W-1];
    end
    if (cmd.quo_mul) quo_r <= DIV_W'(qprod >> QUO_SH);
  end

  // read base i0 = new write pointer - back, with wrap
  logic [PW:0]   base_sum;
  logic [PW-1:0] i0_r, idx;
  logic [PW+1:0] idx_sum, idx_raw;

  assign base_sum = (PW+1)'(wp_new_r) + (PW+1)'(BUFFER_DEPTH) - (PW+1)'(rem_r);
  assign idx_sum  = (PW+2)'(i0_r) + (PW+2)'(cmd.tap_i);
  assign idx_raw  = idx_sum - (PW+2)'(2);

  always_comb begin
    if (idx_sum < (PW+2)'(2))
      idx = PW'(idx_sum + (PW+2)'(BUFFER_DEPTH) - (PW+2)'(2));
    else if (idx_raw >= (PW+2)'(BUFFER_DEPTH))
      idx = PW'(idx_raw - (PW+2)'(BUFFER_DEPTH));
    else
      idx = idx_raw[PW-1:0];
  end

  assign rd_addr = AW'(ch_r) * AW'(BUFFER_DEPTH) + AW'(idx);

  // delay memory
  logic signed [SAMPLE_BITS-1:0] mem_r [MEM_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (cmd.clear)       mem_r[clr_r]   <= '0;
    else if (cmd.accept) mem_r[wr_addr] <= sample_in;
    if (cmd.w_init) rd_r <= mem_r[rd_addr];
  end

  // Lagrange weights: product of five (u - k) factors, Q30 between steps
  logic [15:0]        u;
  logic signed [18:0] f_j;
  logic signed [34:0] p_r;
  logic signed [53:0] wprod_r;
  logic [53:0]        w_mag;
  logic [37:0]        w_q;
  logic [34:0]        p_mag;
  logic [20:0]        n_q;
  logic signed [21:0] n;
  logic signed [25:0] n26, n5, n10, cn;
  logic signed [XP_W-1:0] xprod_r;

  assign u   = (d_r[15:0] != 16'd0) ? 16'(17'h10000 - {1'b0, d_r[15:0]}) : 16'd0;
  assign f_j = $signed({3'b000, u} + ((19'd2 - 19'(cmd.fac_j)) << 16));

  assign w_mag = wprod_r[53] ? 54'(-wprod_r) : 54'(wprod_r);
  assign w_q   = 38'((w_mag + 54'(32768)) >> 16);
  assign p_mag = p_r[34] ? 35'(-p_r) : 35'(p_r);
  assign n_q   = 21'((p_mag + 35'(8192)) >> 14);
  assign n     = p_r[34] ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
  assign n26   = 26'(n);
  assign n5    = (n26 <<< 2) + n26;
  assign n10   = n5 <<< 1;

  always_comb begin
    case (cmd.tap_i)
      3'd0:    cn = -n26;
      3'd1:    cn = n5;
      3'd2:    cn = -n10;
      3'd3:    cn = n10;
      3'd4:    cn = -n5;
      default: cn = n26;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.base)   i0_r <= (base_sum >= (PW+1)'(BUFFER_DEPTH)) ?
                            PW'(base_sum - (PW+1)'(BUFFER_DEPTH)) : base_sum[PW-1:0];
    // first factor times 2^30 / 2^16 is exact
    if (cmd.w_init) p_r <= 35'(f_j) <<< 14;
    else if (cmd.w_rnd) p_r <= wprod_r[53] ? 35'(-w_q) : 35'(w_q);
    if (cmd.w_mul)  wprod_r <= p_r * f_j;
    if (cmd.x_mul)  xprod_r <= XP_W'(cn * rd_r);
    if (cmd.base)   acc_r <= '0;
    else if (cmd.x_acc) acc_r <= acc_r + ACC_W'(xprod_r);
  end

  // output register with saturation
  logic signed [SAMPLE_BITS-1:0] res, out_r;
  logic                          out_valid_r;

  always_comb begin
    if (!neg_r) res = (quo_r > SAT_HI) ? SAMPLE_BITS'(SAT_HI) : quo_r[SAMPLE_BITS-1:0];
    else        res = (quo_r > SAT_LO_MAG) ? SAMPLE_BITS'(SAT_LO_MAG) :
                      SAMPLE_BITS'(DIV_W'(0) - quo_r);
  end

  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n)                     out_valid_r <= 1'b0;
    else if (cmd.out_load)          out_valid_r <= 1'b1;
    else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_r <= res;
  end

  assign out_valid  = out_valid_r;
  assign sample_out = out_r;

endmodule

`default_nettype wire

// File: rtl/lagrange5_modulated_delay_line.sv
// Top level of the chorus delay line: controller plus datapath behind three channels.
// Depends on l5mdl_pkg, l5mdl_if, l5mdl_ctrl and l5mdl_datapath.
//
//   chan      dir  payload                              handshake
//   in_chan   in   channel, sample_in, lfo_value        valid/ready
//   out_chan  out  sample_out                           valid/ready
//   cfg_chan  in   index (0..3), data (29 bits)         valid/ready, ready tied high
//
// A request goes through accept, delay multiply, clamp, two steps for the buffer modulo,
// read base, then six taps (read with first factor, four multiply/round pairs,
// product, accumulate), then rounding, divide by 15 and output load; the next
// request is taken only after that load. After reset a clearing pass zeroes all
// CHANNEL_COUNT*BUFFER_DEPTH memory words; no request is taken meanwhile,
// configuration writes are. A finished result waits in the output register while the
// next request is taken; if that one is done before the first is read, it is held until the register is free.
`default_nettype none

module lagrange5_modulated_delay_line import l5mdl_pkg::*; #(
  parameter int BUFFER_DEPTH  = 8192,
  parameter int CHANNEL_COUNT = 2,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  l5mdl_in_if.sink    in_chan,
  l5mdl_out_if.source out_chan,
  l5mdl_cfg_if.sink   cfg_chan
);

  cmd_t cmd;
  st_t  st;
  logic in_ready;

  assign in_chan.ready  = in_ready;
  assign cfg_chan.ready = 1'b1;

  l5mdl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  l5mdl_datapath #(
    .BUFFER_DEPTH  (BUFFER_DEPTH),
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .cfg_wr     (cfg_chan.valid),
    .cfg_index  (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .channel    (in_chan.channel),
    .sample_in  (in_chan.sample_in),
    .lfo_value  (in_chan.lfo_value),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .sample_out (out_chan.sample_out)
  );

endmodule

`default_nettype wire

// File: rtl/l5mdl_checker.sv
// Port-level checks for the delay line, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module l5mdl_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample_out
);

  // requests taken but not yet delivered
  logic [2:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else        pend_r <= pend_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("result dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd2)
    else $error("more than two requests in flight");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without a request");

endmodule

bind lagrange5_modulated_delay_line l5mdl_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_l5mdl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .sample_out (out_chan.sample_out)
);

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the Lagrange modulated delay line: random and directed requests,
// configuration phases, and a bit-exact predictor of delay, interpolation and saturation.
// Depends on l5mdl_pkg, l5mdl_if and the lagrange5_modulated_delay_line RTL.
`timescale 1ns / 100ps

module tb_top;
  import l5mdl_pkg::*;

  localparam int DEPTH = 8192;
  localparam int CHANS = 2;
  localparam int SB = 16;
  localparam int WATCH_LIMIT = 60000;

  typedef struct packed {
    logic        channel;
    logic [15:0] sample;
    logic [15:0] lfo;
  } req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  l5mdl_in_if #(.SAMPLE_BITS(SB)) in_chan ();
  l5mdl_out_if #(.SAMPLE_BITS(SB)) out_chan ();
  l5mdl_cfg_if cfg_chan ();

  lagrange5_modulated_delay_line #(
    .BUFFER_DEPTH(DEPTH), .CHANNEL_COUNT(CHANS), .SAMPLE_BITS(SB)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan.sink), .out_chan(out_chan.source), .cfg_chan(cfg_chan.sink)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] line_mem [CHANS*DEPTH];
  logic [12:0] wr_ptr [CHANS];
  logic [28:0] centre_q, depth_q, min_q, max_q;

  req_t pending_q[$];
  logic [15:0] expected_q[$];
  int errors = 0;
  int n_results = 0;
  bit calm = 0;       // no idling in the last part
  bit hold_in = 0;    // sender paused by the stimulus
  bit in_taken = 0;   // request accepted at the last rising edge
  int in_gap = 0, out_gap = 0;
  int idle_cycles = 0;

  function automatic longint rnd_div(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [15:0] interpolate(req_t r);
    longint coef [6] = '{-1, 5, -10, 10, -5, 1};
    longint d, f [6], p, acc, res;
    int ch, base, wp, di, fr, u, back, i0, idx;
    ch = r.channel;
    base = ch * DEPTH;
    d = longint'((longint'(depth_q) * longint'(r.lfo ^ 16'h8000)) >>> 15)
        - longint'(depth_q) + longint'(centre_q);
    if (d < longint'(min_q)) d = min_q;
    else if (d > longint'(max_q)) d = max_q;
    wp = wr_ptr[ch];
    line_mem[base + wp] = r.sample;
    wp = (wp + 1) % DEPTH;
    wr_ptr[ch] = wp;
    di = int'(d >>> 16);
    fr = int'(d & 64'hFFFF);
    u = fr != 0 ? 65536 - fr : 0;
    back = di + (fr != 0 ? 1 : 0);
    i0 = (wp + DEPTH - back % DEPTH) % DEPTH;
    for (int j = 0; j < 6; j++) f[j] = longint'(u) - longint'(j - 2) * 65536;
    acc = 0;
    for (int i = 0; i < 6; i++) begin
      p = 64'sd1 << 30;
      idx = (i0 + DEPTH + i - 2) % DEPTH;
      for (int j = 0; j < 6; j++)
        if (j != i) p = rnd_div(p * f[j], 65536);
      p = rnd_div(p, 16384);
      acc += coef[i] * p * longint'(line_mem[base + idx]);
    end
    res = rnd_div(acc, 120 * 65536);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !in_taken) begin
      // hold
    end else begin
      if (in_gap > 0) in_gap <= in_gap - 1;
      if (pending_q.size() > 0 && !hold_in && in_gap == 0 &&
          (calm || $urandom_range(0, 9) != 0)) begin
        in_chan.valid <= 1'b1;
        {in_chan.channel, in_chan.sample_in, in_chan.lfo_value} <= pending_q.pop_front();
      end else begin
        in_chan.valid <= 1'b0;
        if (!calm && in_gap == 0 && $urandom_range(0, 7) == 0)
          in_gap <= $urandom_range(1, 11);
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_chan.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 10);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= in_chan.valid && in_chan.ready;
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_chan.valid && in_chan.ready) begin
        expected_q.push_back(interpolate({in_chan.channel, in_chan.sample_in,
                                          in_chan.lfo_value}));
      end
      if (out_chan.valid && out_chan.ready) begin
        n_results <= n_results + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_chan.sample_out);
          errors <= errors + 1;
        end else if (expected_q[0] !== out_chan.sample_out) begin
          $display("%0t: sample_out expected %h actual %h", $time, expected_q[0],
                   out_chan.sample_out);
          errors <= errors + 1;
          void'(expected_q.pop_front());
        end else begin
          void'(expected_q.pop_front());
        end
      end
      if (idle_cycles > WATCH_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [28:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    case (idx)
      CFG_CENTRE: centre_q = val;
      CFG_DEPTH:  depth_q = val;
      CFG_MIN:    min_q = val;
      default:    max_q = val;
    endcase
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_chan.valid || expected_q.size() > 0)
      @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  task automatic set_delays(logic [28:0] c, logic [28:0] d, logic [28:0] lo,
                            logic [28:0] hi);
    drain();
    write_reg(CFG_CENTRE, c);
    write_reg(CFG_DEPTH, d);
    write_reg(CFG_MIN, lo);
    write_reg(CFG_MAX, hi);
  endtask

  task automatic push_req(logic ch, logic [15:0] s, logic [15:0] l);
    req_t r;
    r.channel = ch; r.sample = s; r.lfo = l;
    pending_q.push_back(r);
  endtask

  task automatic random_reqs(int n, bit small_lfo);
    for (int k = 0; k < n; k++)
      push_req(1'($urandom_range(0, 1)), 16'($urandom),
               small_lfo ? 16'($signed($urandom_range(0, 2000)) - 1000) : 16'($urandom));
  endtask

  initial begin
    in_chan.valid = 1'b0; in_chan.channel = 1'b0;
    in_chan.sample_in = '0; in_chan.lfo_value = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0; cfg_chan.index = CFG_CENTRE; cfg_chan.data = '0;
    centre_q = CENTRE_RST; depth_q = DEPTH_RST; min_q = MIN_RST; max_q = MAX_RST;
    for (int k = 0; k < CHANS*DEPTH; k++) line_mem[k] = '0;
    for (int k = 0; k < CHANS; k++) wr_ptr[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes
    push_req(1'b0, 16'h7FFF, 16'h7FFF);
    push_req(1'b1, 16'h8000, 16'h8000);
    push_req(1'b0, 16'h0000, 16'h0000);
    push_req(1'b1, 16'hFFFF, 16'hFFFF);
    push_req(1'b0, 16'h5555, 16'h0001);
    // short integer delays, zero fraction reproduces a stored sample
    set_delays(29'h20000, 29'd0, 29'd0, 29'h1FFFFFFF);
    for (int k = 0; k < 6; k++) push_req(k[0], k[0] ? 16'h8000 : 16'h7FFF, 16'h1234);
    // fractional delay with full-scale inputs to hit saturation
    set_delays(29'h28000, 29'h10000, 29'd0, 29'h1FFFFFFF);
    for (int k = 0; k < 6; k++) push_req(1'b0, k[1] ? 16'h8000 : 16'h7FFF, 16'($urandom));
    // min above max, and delay beyond the buffer wrapping
    set_delays(29'h1FFFFFFF, 29'h1FFFFFFF, 29'h300000, 29'h100000);
    random_reqs(4, 0);
    set_delays(29'h1FFFFFFF, 29'd0, 29'd0, 29'h1FFFFFFF);
    random_reqs(4, 0);

    // random phases with assorted settings
    for (int ph = 0; ph < 5; ph++) begin
      set_delays(29'($urandom_range(0, 29'h4000000)), 29'($urandom_range(0, 29'h2000000)),
                 29'($urandom_range(0, 29'h40000)),
                 29'($urandom_range(29'h40000, 29'h1FFFFFFF)));
      random_reqs(70, ph[0]);
      if (ph == 2) begin
        // sender pauses until every result is in
        wait (pending_q.size() == 0);
        hold_in = 1;
        while (expected_q.size() > 0 || in_chan.valid) @(posedge clk);
        hold_in = 0;
      end
    end
    set_delays(CENTRE_RST, DEPTH_RST, MIN_RST, MAX_RST);
    random_reqs(175, 0);
    wait (pending_q.size() < 30);
    calm = 1;
    drain();
    $display("Covered %0d results over reset, extreme and random delay settings,", n_results);
    $display("both channels, saturation, wrap and inverted clamp limits.");
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
